@@ sv/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is asserted.
`define BB3_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Clocked check that also holds during reset.
`define BB3_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/bb3_pkg.sv @@
`default_nettype none
package bb3_pkg;

	localparam int PIX_W      = 8;
	localparam int SIZE_W     = 11;
	localparam int SUM_W      = 12;   // nine 8-bit values
	localparam int DIV9_MUL_W = 13;
	localparam int DIV9_SHIFT = 16;
	// floor(x / 9) == (x * 7282) >> 16 for every x below 2296
	localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 13'd7282;

	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_DRAIN = 1'b1;

	// per-transaction decision taken at the input handshake
	typedef struct packed {
		logic take_pix;   // pixel enters the frame
		logic drain;      // drain that yields a result
		logic result;     // transaction yields an output pixel
		logic border;     // output pixel lies on the image border
		logic sel_mid;    // drain reads the middle line (last row)
		logic frame_end;  // last output of the frame
	} bb3_item_t;

endpackage
`default_nettype wire

@@ sv/bb3_ctrl.sv @@
`default_nettype none
module bb3_ctrl import bb3_pkg::*; #(
	parameter int MAX_SIDE = 1024,
	localparam int CW = $clog2(MAX_SIDE),
	localparam int SW = $clog2(MAX_SIDE + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [SIZE_W-1:0] cfg_data,
	input  wire logic              in_fire,
	input  wire logic              mode,
	output bb3_item_t              item,
	output logic      [CW-1:0]     rd_addr
);

	localparam int RESET_SIDE = (64 > MAX_SIDE) ? MAX_SIDE : 64;

	logic [SW-1:0] side_q;
	logic [SW-1:0] side_nxt;
	logic [31:0]   cfg_ext;
	logic [CW-1:0] last_idx;
	logic [CW-1:0] in_col_q, in_row_q, out_col_q, out_row_q;
	logic          in_done_q;
	logic          in_last_col, in_last_row, out_last_col, out_last_row;
	logic          started;

	// side clamp: 0 acts as 1, oversize acts as MAX_SIDE
	always_comb begin
		cfg_ext = 32'(cfg_data);
		if (cfg_ext == 32'd0) begin
			side_nxt = SW'(1);
		end else if (cfg_ext > 32'(MAX_SIDE)) begin
			side_nxt = SW'(MAX_SIDE);
		end else begin
			side_nxt = SW'(cfg_ext);
		end
	end

	assign last_idx     = CW'(side_q - SW'(1));
	assign in_last_col  = (in_col_q == last_idx);
	assign in_last_row  = (in_row_q == last_idx);
	assign out_last_col = (out_col_q == last_idx);
	assign out_last_row = (out_row_q == last_idx);
	// one row plus one pixel already in
	assign started = (in_row_q > CW'(1)) || ((in_row_q == CW'(1)) && (in_col_q != '0));

	always_comb begin
		item.take_pix  = (mode == MODE_PIXEL) && !in_done_q;
		item.drain     = (mode == MODE_DRAIN) && in_done_q;
		item.result    = (item.take_pix && started) || item.drain;
		item.border    = (out_row_q == '0) || out_last_row || (out_col_q == '0) || out_last_col;
		item.sel_mid   = out_last_row;
		item.frame_end = item.drain && out_last_row && out_last_col;
		rd_addr        = (mode == MODE_DRAIN) ? out_col_q : in_col_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q    <= SW'(RESET_SIDE);
			in_col_q  <= '0;
			in_row_q  <= '0;
			in_done_q <= 1'b0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_we) begin
			side_q    <= side_nxt;
			in_col_q  <= '0;
			in_row_q  <= '0;
			in_done_q <= 1'b0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (in_fire) begin
			if (item.take_pix) begin
				if (in_last_col) begin
					in_col_q <= '0;
					in_row_q <= in_last_row ? '0 : in_row_q + CW'(1);
					if (in_last_row) begin
						in_done_q <= 1'b1;
					end
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
			end
			if (item.frame_end) begin
				// new frame
				in_col_q  <= '0;
				in_row_q  <= '0;
				in_done_q <= 1'b0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else if (item.result) begin
				if (out_last_col) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + CW'(1);
				end else begin
					out_col_q <= out_col_q + CW'(1);
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ sv/bb3_line_store.sv @@
`default_nettype none
module bb3_line_store import bb3_pkg::*; #(
	parameter int MAX_SIDE = 1024,
	localparam int CW = $clog2(MAX_SIDE)
) (
	input  wire logic             clk,
	input  wire logic             rd_en,
	input  wire logic [CW-1:0]    rd_addr,
	input  wire logic             wr_en,
	input  wire logic [CW-1:0]    wr_addr,
	input  wire logic [PIX_W-1:0] wr_upper,
	input  wire logic [PIX_W-1:0] wr_middle,
	output logic      [PIX_W-1:0] top_q,
	output logic      [PIX_W-1:0] mid_q
);

	logic [PIX_W-1:0] upper_mem  [MAX_SIDE];
	logic [PIX_W-1:0] middle_mem [MAX_SIDE];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			upper_mem[wr_addr]  <= wr_upper;
			middle_mem[wr_addr] <= wr_middle;
		end
	end

	// registered read, write-first bypass on an address match
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				top_q <= wr_upper;
				mid_q <= wr_middle;
			end else begin
				top_q <= upper_mem[rd_addr];
				mid_q <= middle_mem[rd_addr];
			end
		end
	end

endmodule
`default_nettype wire

@@ sv/bb3_pipe.sv @@
`default_nettype none
module bb3_pipe import bb3_pkg::*; #(
	parameter int MAX_SIDE = 1024,
	localparam int CW = $clog2(MAX_SIDE)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             enter,
	input  wire bb3_item_t        item,
	input  wire logic [PIX_W-1:0] pixel,
	input  wire logic [CW-1:0]    col,
	input  wire logic [PIX_W-1:0] top_rd,
	input  wire logic [PIX_W-1:0] mid_rd,
	input  wire logic             out_ready,
	output logic                  s1_ready,
	output logic                  wr_en,
	output logic      [CW-1:0]    wr_addr,
	output logic      [PIX_W-1:0] wr_upper,
	output logic      [PIX_W-1:0] wr_middle,
	output logic                  out_valid,
	output logic      [PIX_W-1:0] smoothed,
	output logic                  frame_end
);

	localparam int PROD_W = SUM_W + DIV9_MUL_W;

	logic             v1_s1, v2_s2;
	bb3_item_t        item_s1;
	logic [PIX_W-1:0] pix_s1;
	logic [CW-1:0]    col_s1;
	// columns 1 and 2 of the window, rows top to bottom
	logic [PIX_W-1:0] a0_q, a1_q, a2_q, b0_q, b1_q, b2_q;
	logic [SUM_W-1:0] sum, sum_s2;
	logic [PIX_W-1:0] val, val_s2;
	logic             use_sum_s2, fe_s2;
	logic             rdy_o, rdy2, fire1, fire2;
	logic [PROD_W-1:0] prod;

	assign rdy_o    = !out_valid || out_ready;
	assign rdy2     = !v2_s2 || rdy_o;
	assign fire1    = v1_s1 && (!item_s1.result || rdy2);
	assign fire2    = v2_s2 && rdy_o;
	assign s1_ready = !v1_s1 || fire1;

	assign wr_en     = fire1 && item_s1.take_pix;
	assign wr_addr   = col_s1;
	assign wr_upper  = mid_rd;
	assign wr_middle = pix_s1;

	// sum of the window after the shift
	assign sum = SUM_W'(b0_q) + SUM_W'(b1_q) + SUM_W'(b2_q)
		+ SUM_W'(a0_q) + SUM_W'(a1_q) + SUM_W'(a2_q)
		+ SUM_W'(top_rd) + SUM_W'(mid_rd) + SUM_W'(pix_s1);

	always_comb begin
		if (item_s1.drain) begin
			val = item_s1.sel_mid ? mid_rd : top_rd;
		end else begin
			val = b1_q;   // center pixel of the current window
		end
	end

	assign prod = PROD_W'(sum_s2) * PROD_W'(DIV9_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1     <= 1'b0;
			v2_s2     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (enter) begin
				v1_s1 <= 1'b1;
			end else if (fire1) begin
				v1_s1 <= 1'b0;
			end
			if (fire1 && item_s1.result) begin
				v2_s2 <= 1'b1;
			end else if (fire2) begin
				v2_s2 <= 1'b0;
			end
			if (fire2) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (enter) begin
			item_s1 <= item;
			pix_s1  <= pixel;
			col_s1  <= col;
		end
		if (wr_en) begin
			a0_q <= b0_q;
			a1_q <= b1_q;
			a2_q <= b2_q;
			b0_q <= top_rd;
			b1_q <= mid_rd;
			b2_q <= pix_s1;
		end
		if (fire1 && item_s1.result) begin
			sum_s2     <= sum;
			val_s2     <= val;
			use_sum_s2 <= item_s1.take_pix && !item_s1.border;
			fe_s2      <= item_s1.frame_end;
		end
		if (fire2) begin
			smoothed  <= use_sum_s2 ? prod[DIV9_SHIFT +: PIX_W] : val_s2;
			frame_end <= fe_s2;
		end
	end

endmodule
`default_nettype wire

@@ sv/box_blur_3x3_stream.sv @@
// Streaming 3x3 box filter, one pixel or drain transaction per clock unless the output stalls.
// Path: a result passes stage 1, stage 2 and the output register; output
//   pixel p is caused by input pixel p+N+1, or by a drain at frame end.
// Throughput: one transaction per cycle; each line store takes one read and one
//   write in the same cycle, and only a stalled output holds the input back.
// Reset: arst_n clears counters, handshake state and side (64); line stores
//   are not cleared and hold data only once written in the current frame.
`default_nettype none
module box_blur_3x3_stream import bb3_pkg::*; #(
	parameter int MAX_SIDE = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration: side length, write restarts the frame
	input  wire logic              cfg_we,
	input  wire logic [SIZE_W-1:0] cfg_data,
	// input transactions
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [PIX_W-1:0]  pixel,
	input  wire logic              mode,
	// output transactions
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic      [PIX_W-1:0]  smoothed,
	output logic                   frame_end
);

	localparam int CW = $clog2(MAX_SIDE);

	bb3_item_t        item;
	logic [CW-1:0]    rd_addr;
	logic             in_fire;
	logic             enter;
	logic             wr_en;
	logic [CW-1:0]    wr_addr;
	logic [PIX_W-1:0] wr_upper, wr_middle;
	logic [PIX_W-1:0] top_rd, mid_rd;

	assign in_fire = in_valid && in_ready;
	// pixels past the frame and early drains are taken and dropped
	assign enter   = in_fire && (item.take_pix || item.result);

	// frame counters and per-transaction decisions
	bb3_ctrl #(.MAX_SIDE(MAX_SIDE)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_fire  (in_fire),
		.mode     (mode),
		.item     (item),
		.rd_addr  (rd_addr)
	);

	// two rows of history, read when the transaction enters stage 1
	bb3_line_store #(.MAX_SIDE(MAX_SIDE)) u_lines (
		.clk       (clk),
		.rd_en     (enter),
		.rd_addr   (rd_addr),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_upper  (wr_upper),
		.wr_middle (wr_middle),
		.top_q     (top_rd),
		.mid_q     (mid_rd)
	);

	// window, neighborhood sum, divide by nine, output register
	bb3_pipe #(.MAX_SIDE(MAX_SIDE)) u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.enter     (enter),
		.item      (item),
		.pixel     (pixel),
		.col       (rd_addr),
		.top_rd    (top_rd),
		.mid_rd    (mid_rd),
		.out_ready (out_ready),
		.s1_ready  (in_ready),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_upper  (wr_upper),
		.wr_middle (wr_middle),
		.out_valid (out_valid),
		.smoothed  (smoothed),
		.frame_end (frame_end)
	);

endmodule
`default_nettype wire

@@ sv/bb3_checker.sv @@
`default_nettype none
`include "assert_macros.svh"
module bb3_checker import bb3_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              cfg_we,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic [PIX_W-1:0]  pixel,
	input wire logic              mode,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [PIX_W-1:0]  smoothed,
	input wire logic              frame_end
);

	// a stalled result holds
	`BB3_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(smoothed) && $stable(frame_end), "stalled output changed")

	// a waiting input transaction holds
	`BB3_ASSERT(a_in_hold, in_valid && !in_ready |=> in_valid && $stable(pixel) && $stable(mode), "waiting input changed")

	// with the output register empty nothing upstream can stall
	`BB3_ASSERT(a_in_free, !out_valid |-> in_ready, "input stalled with empty output")

	// side changes only with no output pending
	`BB3_ASSERT(a_cfg_idle, cfg_we |-> !out_valid, "side written with an output pending")

	// reset leaves no output transaction pending
	`BB3_ASSERT_RST(a_rst_quiet, !arst_n |-> !out_valid, "output valid in reset")

endmodule

bind box_blur_3x3_stream bb3_checker u_chk (.*);
`default_nettype wire

@@ tb/sv/tb_box_blur_3x3_stream.sv @@
`timescale 1ns / 100ps

module tb_box_blur_3x3_stream;
	import bb3_pkg::*;

	localparam int MAX_SIDE      = 1024;
	localparam int RESET_SIDE    = 64;
	localparam int CYCLE_LIMIT   = 400000;
	// settling wait after the block has drained, before a side change
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 20;
	// receiver hold-off, long enough for the block to back up into in_ready
	localparam int RX_HOLD       = 300;
	localparam int PHASE_ITEMS   = 90;

	// one output pixel as the block should deliver it
	typedef struct packed {
		logic [PIX_W-1:0] smoothed;
		logic             frame_end;
	} blur_px_t;

	// directed row: either a side change or one transaction
	typedef struct packed {
		logic              set_side;
		logic [SIZE_W-1:0] side;
		logic [PIX_W-1:0]  pix;
		logic              md;
		logic              typed;   // expected pixel written in the row
		blur_px_t          exp_px;
	} dir_row_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [SIZE_W-1:0] cfg_data;
	logic              in_valid;
	logic              in_ready;
	logic [PIX_W-1:0]  pixel;
	logic              mode;
	logic              out_valid;
	logic              out_ready;
	logic [PIX_W-1:0]  smoothed;
	logic              frame_end;

	// filter state as the testbench sees it
	logic [SIZE_W-1:0] side_reg;
	logic [PIX_W-1:0]  line_upper  [MAX_SIDE];
	logic [PIX_W-1:0]  line_middle [MAX_SIDE];
	logic [PIX_W-1:0]  win [3][3];
	int unsigned       pix_in;
	int unsigned       pix_out;

	blur_px_t px_due [$];   // output pixels still owed by the block
	dir_row_t dir_rows [$];

	int tx_idle_pct;
	int rx_idle_pct;
	int hold_kicks;
	int err_count;
	int cycle_count;
	int items_offered;
	int items_counted;
	int px_checked;
	int frames_done;
	int side_writes;

	box_blur_3x3_stream #(
		.MAX_SIDE(MAX_SIDE)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel(pixel),
		.mode(mode),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.smoothed(smoothed),
		.frame_end(frame_end)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// side in force: 0 behaves as 1, anything past the line length as the line length
	function automatic int unsigned frame_side();
		if (side_reg == 0)
			return 1;
		if (side_reg > MAX_SIDE)
			return MAX_SIDE;
		return side_reg;
	endfunction

	// counts and window clear; the line stores keep their contents
	function automatic void frame_restart();
		pix_in  = 0;
		pix_out = 0;
		for (int k = 0; k < 3; k++)
			for (int m = 0; m < 3; m++)
				win[k][m] = '0;
	endfunction

	function automatic logic [PIX_W-1:0] rand_pixel();
		// lean on the extremes now and then, otherwise uniform
		if ($urandom_range(0, 7) == 0)
			return ($urandom_range(0, 1) == 1) ? {PIX_W{1'b1}} : '0;
		return PIX_W'($urandom_range(0, 255));
	endfunction

	function automatic dir_row_t row_side(input logic [SIZE_W-1:0] v);
		dir_row_t r;
		r = '0;
		r.set_side = 1'b1;
		r.side = v;
		return r;
	endfunction

	function automatic dir_row_t row_item(input logic [PIX_W-1:0] pv, input logic md,
			input logic typed, input logic [PIX_W-1:0] ev, input logic ee);
		dir_row_t r;
		r = '0;
		r.pix = pv;
		r.md = md;
		r.typed = typed;
		r.exp_px.smoothed = ev;
		r.exp_px.frame_end = ee;
		return r;
	endfunction

	// Advance the filter by one accepted transaction.
	// took: the transaction changed the frame; got: it yields an output pixel.
	task automatic blur_step(input logic [PIX_W-1:0] pv, input logic md,
			output bit took, output bit got, output blur_px_t res);
		int unsigned n, total, q, col, p, r, c, sum;
		int k, m;
		logic [PIX_W-1:0] top, mid, prev_mid, val;
		n = frame_side();
		total = n * n;
		took = 0;
		got = 0;
		res = '0;
		if (md == MODE_PIXEL) begin
			// pixels past the end of the frame are dropped
			if (pix_in >= total)
				return;
			q = pix_in;
			col = q % n;
			top = line_upper[col];
			mid = line_middle[col];
			line_upper[col] = mid;
			line_middle[col] = pv;
			prev_mid = win[1][2];
			for (k = 0; k < 3; k++) begin
				win[k][0] = win[k][1];
				win[k][1] = win[k][2];
			end
			win[0][2] = top;
			win[1][2] = mid;
			win[2][2] = pv;
			pix_in = q + 1;
			took = 1;
			// output p waits for input p+N+1
			if (q < n + 1)
				return;
			p = q - n - 1;
			r = p / n;
			c = p % n;
			if (r == 0 || r == n - 1 || c == 0 || c == n - 1) begin
				// at column 0 the center is read from before the shift
				val = (col >= 1) ? win[1][1] : prev_mid;
			end else begin
				sum = 0;
				for (k = 0; k < 3; k++)
					for (m = 0; m < 3; m++)
						sum += win[k][m];
				val = PIX_W'(sum / 9);
			end
			pix_out = p + 1;
			got = 1;
			res.smoothed = val;
			res.frame_end = 1'b0;
		end else begin
			// drain only flushes once every pixel of the frame is in
			if (pix_in < total || pix_out >= total)
				return;
			p = pix_out;
			r = p / n;
			c = p % n;
			val = (r == n - 1) ? line_middle[c] : line_upper[c];
			pix_out = p + 1;
			took = 1;
			got = 1;
			res.smoothed = val;
			res.frame_end = (pix_out == total);
			if (res.frame_end) begin
				frames_done++;
				frame_restart();
			end
		end
	endtask

	// One input transaction: optional idle gap, then hold valid until accepted.
	// Returns just after the accepting edge with valid still high.
	task automatic offer(input logic [PIX_W-1:0] pv, input logic md,
			input logic typed, input blur_px_t typed_px);
		bit took, got;
		blur_px_t res;
		@(negedge clk);
		if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			in_valid = 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(0, 99) < tx_idle_pct);
		end
		in_valid = 1'b1;
		pixel = pv;
		mode = md;
		do
			@(posedge clk);
		while (!in_ready);
		items_offered++;
		blur_step(pv, md, took, got, res);
		if (typed)
			px_due.push_back(typed_px);
		else if (got)
			px_due.push_back(res);
		if (took)
			items_counted++;
	endtask

	// stop offering until the block has handed over everything it owes
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (px_due.size() != 0)
			@(posedge clk);
	endtask

	// side change only with the block idle; it restarts the frame
	task automatic side_write(input logic [SIZE_W-1:0] v);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 1'b0;
		side_reg = v;
		frame_restart();
		side_writes++;
	endtask

	// Receiver: random ready, or a long hold-off when the stimulus asks for one.
	initial begin : rx_drive
		int hold_left;
		int kicks_seen;
		hold_left = 0;
		kicks_seen = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (kicks_seen != hold_kicks) begin
				kicks_seen = hold_kicks;
				hold_left = RX_HOLD;
			end
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else begin
				out_ready = ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	// Every output transaction is matched against the oldest owed pixel.
	always @(posedge clk) begin : out_check
		blur_px_t want;
		if (arst_n && out_valid && out_ready) begin
			if (px_due.size() == 0) begin
				err_count++;
				$display("%0t: output with nothing owed: smoothed %0d frame_end %0d",
					$time, smoothed, frame_end);
			end else begin
				want = px_due.pop_front();
				px_checked++;
				if (smoothed !== want.smoothed) begin
					err_count++;
					$display("%0t: smoothed expected %0d actual %0d",
						$time, want.smoothed, smoothed);
				end
				if (frame_end !== want.frame_end) begin
					err_count++;
					$display("%0t: frame_end expected %0d actual %0d",
						$time, want.frame_end, frame_end);
				end
			end
		end
	end

	// Hard stop if the block hangs.
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: no progress, %0d pixels still owed", $time, px_due.size());
		$display("tb_box_blur_3x3_stream failed");
		$finish;
	end

	initial begin : stimulus
		int i, phase, target, cut_at;
		int unsigned n, total;
		logic [SIZE_W-1:0] side_pick;
		bit frame_open, held, paused;

		// all inputs known from time zero
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		pixel = '0;
		mode = MODE_PIXEL;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_kicks = 0;
		err_count = 0;
		items_offered = 0;
		items_counted = 0;
		px_checked = 0;
		frames_done = 0;
		side_writes = 0;

		// predictor reset: stores read as zero, side back to its default
		side_reg = RESET_SIDE;
		for (i = 0; i < MAX_SIDE; i++) begin
			line_upper[i] = '0;
			line_middle[i] = '0;
		end
		frame_restart();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// ---- directed rows ----
		// drain before the frame is in: ignored at the default side
		dir_rows.push_back(row_item(8'h00, MODE_DRAIN, 0, 8'h00, 0));
		// 1x1 frame: pixel, an extra pixel that is dropped, drain returns the copy
		dir_rows.push_back(row_side(11'd1));
		dir_rows.push_back(row_item(8'hFF, MODE_PIXEL, 0, 8'h00, 0));
		dir_rows.push_back(row_item(8'h07, MODE_PIXEL, 0, 8'h00, 0));
		dir_rows.push_back(row_item(8'h5A, MODE_DRAIN, 1, 8'hFF, 1));
		// side 0 acts as 1
		dir_rows.push_back(row_side(11'd0));
		dir_rows.push_back(row_item(8'h00, MODE_PIXEL, 0, 8'h00, 0));
		dir_rows.push_back(row_item(8'hFF, MODE_DRAIN, 1, 8'h00, 1));
		// 2x2 frame: all border copies, three of them flushed by drains
		dir_rows.push_back(row_side(11'd2));
		dir_rows.push_back(row_item(8'hFF, MODE_PIXEL, 0, 8'h00, 0));
		dir_rows.push_back(row_item(8'h00, MODE_PIXEL, 0, 8'h00, 0));
		dir_rows.push_back(row_item(8'h80, MODE_PIXEL, 0, 8'h00, 0));
		dir_rows.push_back(row_item(8'h01, MODE_PIXEL, 1, 8'hFF, 0));
		dir_rows.push_back(row_item(8'h00, MODE_DRAIN, 1, 8'h00, 0));
		dir_rows.push_back(row_item(8'hFF, MODE_DRAIN, 1, 8'h80, 0));
		dir_rows.push_back(row_item(8'h33, MODE_DRAIN, 1, 8'h01, 1));
		// 3x3 frame: one interior pixel, checked by the predictor
		dir_rows.push_back(row_side(11'd3));
		dir_rows.push_back(row_item(8'h00, MODE_PIXEL, 0, 8'h00, 0));
		dir_rows.push_back(row_item(8'hFF, MODE_PIXEL, 0, 8'h00, 0));
		dir_rows.push_back(row_item(8'h00, MODE_PIXEL, 0, 8'h00, 0));
		dir_rows.push_back(row_item(8'hFF, MODE_PIXEL, 0, 8'h00, 0));
		dir_rows.push_back(row_item(8'hFF, MODE_PIXEL, 0, 8'h00, 0));
		dir_rows.push_back(row_item(8'hFF, MODE_PIXEL, 0, 8'h00, 0));
		dir_rows.push_back(row_item(8'h00, MODE_PIXEL, 0, 8'h00, 0));
		dir_rows.push_back(row_item(8'hFF, MODE_PIXEL, 0, 8'h00, 0));
		dir_rows.push_back(row_item(8'h00, MODE_PIXEL, 0, 8'h00, 0));
		dir_rows.push_back(row_item(8'h00, MODE_DRAIN, 0, 8'h00, 0));
		dir_rows.push_back(row_item(8'h00, MODE_DRAIN, 0, 8'h00, 0));
		dir_rows.push_back(row_item(8'h00, MODE_DRAIN, 0, 8'h00, 0));
		dir_rows.push_back(row_item(8'h00, MODE_DRAIN, 0, 8'h00, 0));
		// side past the line length clamps; early drain again
		dir_rows.push_back(row_side(11'h7FF));
		dir_rows.push_back(row_item(8'hC3, MODE_DRAIN, 0, 8'h00, 0));

		foreach (dir_rows[j]) begin
			if (dir_rows[j].set_side)
				side_write(dir_rows[j].side);
			else
				offer(dir_rows[j].pix, dir_rows[j].md, dir_rows[j].typed,
					dir_rows[j].exp_px);
		end

		// ---- random frames under three idling regimes ----
		frame_open = 1;   // last directed frame was left unfinished
		paused = 0;
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 11;
					rx_idle_pct = 87;
				end
				1: begin
					tx_idle_pct = 87;
					rx_idle_pct = 11;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			held = 0;
			target = items_counted + PHASE_ITEMS;
			while (items_counted < target) begin
				// new side after an open frame or at phase start, else three times in four
				if (frame_open || !held || $urandom_range(0, 3) != 0) begin
					if (!held) begin
						side_pick = SIZE_W'($urandom_range(6, 12));
					end else begin
						case ($urandom_range(0, 15))
							0: side_pick = '0;
							1: side_pick = SIZE_W'(1);
							2: side_pick = SIZE_W'(2);
							3: side_pick = SIZE_W'($urandom_range(13, 32));
							default: side_pick = SIZE_W'($urandom_range(3, 12));
						endcase
					end
					side_write(side_pick);
				end
				n = frame_side();
				total = n * n;
				// now and then a frame is abandoned part way through
				cut_at = (held && $urandom_range(0, 9) == 0) ? $urandom_range(0, total - 1) : -1;

				for (i = 0; i < total && i != cut_at; i++) begin
					// early drain: no effect
					if ($urandom_range(0, 24) == 0)
						offer(rand_pixel(), MODE_DRAIN, 0, '0);
					// block outputs are about to start: freeze the receiver
					if (!held && n >= 4 && i == n + 1) begin
						hold_kicks++;
						held = 1;
					end
					if (n >= 3 && i == total / 2 && (!paused || $urandom_range(0, 15) == 0)) begin
						wait_drained();
						paused = 1;
					end
					offer(rand_pixel(), MODE_PIXEL, 0, '0);
				end

				if (i == total) begin
					// flush, with a stray pixel now and then that must be dropped
					while (pix_in != 0) begin
						if ($urandom_range(0, 19) == 0)
							offer(rand_pixel(), MODE_PIXEL, 0, '0);
						offer(rand_pixel(), MODE_DRAIN, 0, '0);
					end
					frame_open = 0;
				end else begin
					frame_open = 1;
				end
			end
		end

		// largest side: only the first row plus a few pixels, enough for
		// the first border copies to come out
		side_write(SIZE_W'(MAX_SIDE));
		offer(rand_pixel(), MODE_DRAIN, 0, '0);
		for (i = 0; i < MAX_SIDE + 8; i++)
			offer(rand_pixel(), MODE_PIXEL, 0, '0);

		// ---- wind down ----
		@(negedge clk);
		in_valid = 1'b0;
		while (px_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d input transactions (%0d took effect), %0d output pixels checked",
			items_offered, items_counted, px_checked);
		$display("%0d frames flushed, %0d side changes, %0d errors in %0d cycles",
			frames_done, side_writes, err_count, cycle_count);
		if (err_count == 0)
			$display("tb_box_blur_3x3_stream passed");
		else
			$display("tb_box_blur_3x3_stream failed");
		$finish;
	end

endmodule
